// ===== hdl/pfsb_pkg.sv =====
// shared types and constants of the page frame sprite blitter
// no dependencies

package pfsb_pkg;

  localparam logic [1:0] OP_DRAW       = 2'd0;
  localparam logic [1:0] OP_READ       = 2'd1;
  localparam logic [1:0] OP_READ_CLEAR = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_FIRST  = 4'b0100,
    ST_SECOND = 4'b1000
  } state_e;

  typedef struct packed {
    logic       en_lo;
    logic       en_hi;
    logic [4:0] page_lo;
    logic [4:0] page_hi;
    logic [7:0] col;
    logic [7:0] bits_lo;
    logic [7:0] bits_hi;
  } place_t;

endpackage

// ===== hdl/pfsb_place.sv =====
// placement of one sprite byte: target pages, column, shifted bits and clipping
// depends on pfsb_pkg

module pfsb_place #(
  parameter int PAGE_COUNT   = 8,
  parameter int COLUMN_COUNT = 128
) (
  input  logic [7:0]      origin_line_i,
  input  logic [7:0]      origin_column_i,
  input  logic [2:0]      sprite_page_i,
  input  logic [6:0]      sprite_column_i,
  input  logic [7:0]      pixel_byte_i,
  output pfsb_pkg::place_t place_o
);

  logic [5:0]  page_lo;
  logic [5:0]  page_hi;
  logic [9:0]  col;
  logic [2:0]  shift;
  logic [15:0] shifted;
  logic        col_ok;
  logic        lo_ok;
  logic        hi_ok;

  // floor division by 8 of the signed line is an arithmetic shift
  assign page_lo = {origin_line_i[7], origin_line_i[7:3]} + {3'b000, sprite_page_i};
  assign page_hi = page_lo + 6'd1;
  assign shift   = origin_line_i[2:0];
  assign col     = {{2{origin_column_i[7]}}, origin_column_i} + {3'b000, sprite_column_i};
  assign shifted = {8'h00, pixel_byte_i} << shift;

  assign col_ok = !col[9] && (col < 10'(COLUMN_COUNT));
  assign lo_ok  = !page_lo[5] && (page_lo[4:0] < 5'(PAGE_COUNT));
  assign hi_ok  = !page_hi[5] && (page_hi[4:0] < 5'(PAGE_COUNT)) && (shift != 3'd0);

  always_comb begin
    place_o.en_lo   = col_ok && lo_ok;
    place_o.en_hi   = col_ok && hi_ok;
    place_o.page_lo = page_lo[4:0];
    place_o.page_hi = page_hi[4:0];
    place_o.col     = col[7:0];
    place_o.bits_lo = shifted[7:0];
    place_o.bits_hi = shifted[15:8];
  end

endmodule

// ===== hdl/page_frame_sprite_blitter_unit.sv =====
// top level of the page frame sprite blitter: frame store memory and its sequencer
// depends on pfsb_pkg and pfsb_place
// read result: strobed for one cycle, in the cycle after the request is taken
// sequencing: read and draw pass ST_FIRST, a draw spanning two pages ST_SECOND too; clipped
// draw and unused op stay idle; busy holds off new requests until idle; the receiver cannot stall
// reset: a clearing pass writes zero to every entry of the store while busy is high

module page_frame_sprite_blitter_unit #(
  parameter int PAGE_COUNT   = 8,
  parameter int COLUMN_COUNT = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] op_i,
  input  logic [7:0] origin_line_i,
  input  logic [7:0] origin_column_i,
  input  logic [2:0] sprite_page_i,
  input  logic [6:0] sprite_column_i,
  input  logic [7:0] pixel_byte_i,
  input  logic [2:0] read_page_i,
  input  logic [6:0] read_column_i,
  output logic       strobe_o,
  output logic [7:0] frame_byte_o
);

  localparam int DEPTH = PAGE_COUNT * COLUMN_COUNT;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic [AW-1:0] addr_of(input logic [4:0] pg, input logic [7:0] cl);
    return AW'(({11'b0, pg} * 16'(COLUMN_COUNT)) + {8'b0, cl});
  endfunction

  pfsb_pkg::state_e state_q, state_d;
  pfsb_pkg::place_t place;

  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [AW-1:0] addr0_q, addr0_d, addr1_q, addr1_d;
  logic [7:0]    bits0_q, bits0_d, bits1_q, bits1_d;
  logic          two_q, two_d;
  logic          is_read_q, is_read_d;
  logic          clear_q, clear_d;
  logic          rd_ok_q, rd_ok_d;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          accept;
  logic          rd_in_range;

  pfsb_place #(
    .PAGE_COUNT  (PAGE_COUNT),
    .COLUMN_COUNT(COLUMN_COUNT)
  ) u_place (
    .origin_line_i  (origin_line_i),
    .origin_column_i(origin_column_i),
    .sprite_page_i  (sprite_page_i),
    .sprite_column_i(sprite_column_i),
    .pixel_byte_i   (pixel_byte_i),
    .place_o        (place)
  );

  assign busy        = (state_q != pfsb_pkg::ST_IDLE);
  assign accept      = start && !busy;
  assign rd_in_range = (5'(read_page_i) < 5'(PAGE_COUNT)) &&
                       (9'(read_column_i) < 9'(COLUMN_COUNT));

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    addr0_d   = addr0_q;
    addr1_d   = addr1_q;
    bits0_d   = bits0_q;
    bits1_d   = bits1_q;
    two_d     = two_q;
    is_read_d = is_read_q;
    clear_d   = clear_q;
    rd_ok_d   = rd_ok_q;
    rd_en     = 1'b0;
    rd_addr   = addr1_q;
    we        = 1'b0;
    waddr     = addr0_q;
    wdata     = rdata_q | bits0_q;
    case (state_q)
      pfsb_pkg::ST_CLEAR: begin
        we        = 1'b1;
        waddr     = clr_cnt_q;
        wdata     = 8'h00;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          state_d = pfsb_pkg::ST_IDLE;
        end
      end
      pfsb_pkg::ST_IDLE: begin
        if (accept) begin
          if (op_i == pfsb_pkg::OP_DRAW) begin
            is_read_d = 1'b0;
            clear_d   = 1'b0;
            rd_ok_d   = 1'b0;
            two_d     = place.en_lo && place.en_hi;
            addr1_d   = addr_of(place.page_hi, place.col);
            bits1_d   = place.bits_hi;
            if (place.en_lo) begin
              addr0_d = addr_of(place.page_lo, place.col);
              bits0_d = place.bits_lo;
            end else begin
              addr0_d = addr_of(place.page_hi, place.col);
              bits0_d = place.bits_hi;
            end
            if (place.en_lo || place.en_hi) begin
              rd_en   = 1'b1;
              rd_addr = addr0_d;
              state_d = pfsb_pkg::ST_FIRST;
            end
          end else if (op_i == pfsb_pkg::OP_READ || op_i == pfsb_pkg::OP_READ_CLEAR) begin
            is_read_d = 1'b1;
            clear_d   = (op_i == pfsb_pkg::OP_READ_CLEAR);
            rd_ok_d   = rd_in_range;
            two_d     = 1'b0;
            bits0_d   = 8'h00;
            addr0_d   = addr_of(5'(read_page_i), 8'(read_column_i));
            rd_en     = rd_in_range;
            rd_addr   = addr0_d;
            state_d   = pfsb_pkg::ST_FIRST;
          end
        end
      end
      pfsb_pkg::ST_FIRST: begin
        waddr = addr0_q;
        if (is_read_q) begin
          we    = clear_q && rd_ok_q;
          wdata = 8'h00;
        end else begin
          we    = 1'b1;
          wdata = rdata_q | bits0_q;
        end
        if (two_q) begin
          rd_en   = 1'b1;
          rd_addr = addr1_q;
          state_d = pfsb_pkg::ST_SECOND;
        end else begin
          state_d = pfsb_pkg::ST_IDLE;
        end
      end
      pfsb_pkg::ST_SECOND: begin
        we      = 1'b1;
        waddr   = addr1_q;
        wdata   = rdata_q | bits1_q;
        state_d = pfsb_pkg::ST_IDLE;
      end
      default: begin
        state_d = pfsb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pfsb_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
      two_q     <= 1'b0;
      is_read_q <= 1'b0;
      clear_q   <= 1'b0;
      rd_ok_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      two_q     <= two_d;
      is_read_q <= is_read_d;
      clear_q   <= clear_d;
      rd_ok_q   <= rd_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr0_q <= addr0_d;
    addr1_q <= addr1_d;
    bits0_q <= bits0_d;
    bits1_q <= bits1_d;
  end

  // frame store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign strobe_o     = (state_q == pfsb_pkg::ST_FIRST) && is_read_q;
  assign frame_byte_o = rd_ok_q ? rdata_q : 8'h00;

  a_read_strobes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op_i == pfsb_pkg::OP_READ || op_i == pfsb_pkg::OP_READ_CLEAR)) |=> strobe_o)
    else $error("read request without result");

  a_draw_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == pfsb_pkg::OP_DRAW) |=> !strobe_o)
    else $error("draw request produced a result");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o)
    else $error("result repeated");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && rd_en) |-> (waddr != rd_addr))
    else $error("read and write of the same entry in one cycle");

  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pfsb_pkg::ST_CLEAR && clr_cnt_q != AW'(DEPTH - 1)) |=> busy)
    else $error("requests taken before the store is cleared");

endmodule

// ===== tb/sv/tb_page_frame_sprite_blitter_unit.sv =====
// testbench of page_frame_sprite_blitter_unit: directed rows, then random draws, reads and unused ops
// a predictor keeps its own copy of the frame store and checks each strobed frame byte
// depends on pfsb_pkg and page_frame_sprite_blitter_unit
`timescale 1ns / 1ps

module tb_page_frame_sprite_blitter_unit;

  localparam int PAGE_COUNT     = 8;
  localparam int COLUMN_COUNT   = 128;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_REQUESTS = 425;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] origin_line;
    logic [7:0] origin_column;
    logic [2:0] sprite_page;
    logic [6:0] sprite_column;
    logic [7:0] pixel_byte;
    logic [2:0] read_page;
    logic [6:0] read_column;
    logic       typed;
    logic [7:0] typed_byte;
  } blit_req_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] op_i = pfsb_pkg::OP_DRAW;
  logic [7:0] origin_line_i = '0;
  logic [7:0] origin_column_i = '0;
  logic [2:0] sprite_page_i = '0;
  logic [6:0] sprite_column_i = '0;
  logic [7:0] pixel_byte_i = '0;
  logic [2:0] read_page_i = '0;
  logic [6:0] read_column_i = '0;
  logic       strobe_o;
  logic [7:0] frame_byte_o;

  logic       typed_valid = 1'b0;
  logic [7:0] typed_byte = '0;

  logic [7:0] frame_image [PAGE_COUNT*COLUMN_COUNT] = '{default: '0};
  logic [7:0] pending_bytes [$];
  int         fail_count = 0;
  int         stall_cycles = 0;
  int         last_page = 0;
  int         last_col = 0;

  blit_req_t directed_rows [0:24] = '{
    '{pfsb_pkg::OP_READ,       8'h00, 8'h00, 3'd0, 7'd0,   8'h00, 3'd0, 7'd0,   1'b1, 8'h00},
    '{pfsb_pkg::OP_READ_CLEAR, 8'h00, 8'h00, 3'd0, 7'd0,   8'h00, 3'd7, 7'd127, 1'b1, 8'h00},
    '{pfsb_pkg::OP_DRAW,       8'h00, 8'h00, 3'd0, 7'd0,   8'hFF, 3'd0, 7'd0,   1'b0, 8'h00},
    '{pfsb_pkg::OP_READ,       8'h00, 8'h00, 3'd0, 7'd0,   8'h00, 3'd0, 7'd0,   1'b1, 8'hFF},
    '{pfsb_pkg::OP_DRAW,       8'h03, 8'h0A, 3'd0, 7'd0,   8'hFF, 3'd0, 7'd0,   1'b0, 8'h00},
    '{pfsb_pkg::OP_READ,       8'h00, 8'h00, 3'd0, 7'd0,   8'h00, 3'd0, 7'd10,  1'b1, 8'hF8},
    '{pfsb_pkg::OP_READ,       8'h00, 8'h00, 3'd0, 7'd0,   8'h00, 3'd1, 7'd10,  1'b1, 8'h07},
    '{pfsb_pkg::OP_DRAW,       8'h80, 8'h00, 3'd7, 7'd5,   8'hA5, 3'd0, 7'd0,   1'b0, 8'h00},
    '{pfsb_pkg::OP_DRAW,       8'hFB, 8'h7F, 3'd0, 7'd0,   8'hFF, 3'd0, 7'd0,   1'b0, 8'h00},
    '{pfsb_pkg::OP_READ,       8'h00, 8'h00, 3'd0, 7'd0,   8'h00, 3'd0, 7'd127, 1'b0, 8'h00},
    '{pfsb_pkg::OP_DRAW,       8'h7F, 8'h14, 3'd0, 7'd0,   8'hFF, 3'd0, 7'd0,   1'b0, 8'h00},
    '{pfsb_pkg::OP_DRAW,       8'h00, 8'h7F, 3'd0, 7'd127, 8'hFF, 3'd0, 7'd0,   1'b0, 8'h00},
    '{pfsb_pkg::OP_DRAW,       8'h00, 8'h80, 3'd0, 7'd127, 8'hFF, 3'd0, 7'd0,   1'b0, 8'h00},
    '{pfsb_pkg::OP_DRAW,       8'h3C, 8'h32, 3'd0, 7'd0,   8'hFF, 3'd0, 7'd0,   1'b0, 8'h00},
    '{pfsb_pkg::OP_READ_CLEAR, 8'h00, 8'h00, 3'd0, 7'd0,   8'h00, 3'd7, 7'd50,  1'b0, 8'h00},
    '{pfsb_pkg::OP_READ,       8'h00, 8'h00, 3'd0, 7'd0,   8'h00, 3'd7, 7'd50,  1'b0, 8'h00},
    '{OP_UNUSED,               8'h00, 8'h14, 3'd0, 7'd0,   8'hFF, 3'd0, 7'd20,  1'b0, 8'h00},
    '{pfsb_pkg::OP_READ,       8'h00, 8'h00, 3'd0, 7'd0,   8'h00, 3'd0, 7'd20,  1'b0, 8'h00},
    '{pfsb_pkg::OP_DRAW,       8'hFF, 8'hFF, 3'd1, 7'd1,   8'h55, 3'd0, 7'd0,   1'b0, 8'h00},
    '{pfsb_pkg::OP_READ_CLEAR, 8'h00, 8'h00, 3'd0, 7'd0,   8'h00, 3'd0, 7'd0,   1'b0, 8'h00},
    '{pfsb_pkg::OP_READ,       8'h00, 8'h00, 3'd0, 7'd0,   8'h00, 3'd1, 7'd0,   1'b0, 8'h00},
    '{pfsb_pkg::OP_DRAW,       8'h07, 8'h05, 3'd7, 7'd0,   8'h81, 3'd0, 7'd0,   1'b0, 8'h00},
    '{pfsb_pkg::OP_READ,       8'h00, 8'h00, 3'd0, 7'd0,   8'h00, 3'd7, 7'd5,   1'b0, 8'h00},
    '{pfsb_pkg::OP_DRAW,       8'h00, 8'h00, 3'd0, 7'd0,   8'h00, 3'd0, 7'd0,   1'b0, 8'h00},
    '{pfsb_pkg::OP_READ,       8'h00, 8'h00, 3'd0, 7'd0,   8'h00, 3'd0, 7'd0,   1'b0, 8'h00}
  };

  page_frame_sprite_blitter_unit #(
    .PAGE_COUNT  (PAGE_COUNT),
    .COLUMN_COUNT(COLUMN_COUNT)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .origin_line_i  (origin_line_i),
    .origin_column_i(origin_column_i),
    .sprite_page_i  (sprite_page_i),
    .sprite_column_i(sprite_column_i),
    .pixel_byte_i   (pixel_byte_i),
    .read_page_i    (read_page_i),
    .read_column_i  (read_column_i),
    .strobe_o       (strobe_o),
    .frame_byte_o   (frame_byte_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void blit_frame(input logic [1:0] op, input logic [7:0] oline,
                                     input logic [7:0] ocol, input logic [2:0] spage,
                                     input logic [6:0] scol, input logic [7:0] pix,
                                     input logic [2:0] rpage, input logic [6:0] rcol,
                                     output bit has_byte, output logic [7:0] rd_byte);
    int ln;
    int col;
    int pg;
    int sh;
    int idx;
    has_byte = 1'b0;
    rd_byte = '0;
    case (op)
      pfsb_pkg::OP_DRAW: begin
        ln = $signed(oline);
        col = $signed(ocol);
        col = col + int'(scol);
        pg = (ln >>> 3) + int'(spage);
        sh = ln & 7;
        if (col >= 0 && col < COLUMN_COUNT) begin
          if (pg >= 0 && pg < PAGE_COUNT)
            frame_image[pg*COLUMN_COUNT + col] |= 8'(pix << sh);
          if (sh != 0 && pg >= -1 && pg < PAGE_COUNT - 1)
            frame_image[(pg + 1)*COLUMN_COUNT + col] |= 8'(pix >> (8 - sh));
        end
      end
      pfsb_pkg::OP_READ, pfsb_pkg::OP_READ_CLEAR: begin
        has_byte = 1'b1;
        if (int'(rpage) < PAGE_COUNT && int'(rcol) < COLUMN_COUNT) begin
          idx = int'(rpage)*COLUMN_COUNT + int'(rcol);
          rd_byte = frame_image[idx];
          if (op == pfsb_pkg::OP_READ_CLEAR) frame_image[idx] = '0;
        end
      end
      default: ;
    endcase
  endfunction

  // checks strobed bytes, then predicts the request taken at this edge
  always @(posedge clk_i) begin
    bit         has_byte;
    logic [7:0] rd_byte;
    logic [7:0] want;
    if (rst_ni) begin
      if (strobe_o) begin
        if (pending_bytes.size() == 0) begin
          $error("frame_byte: expected none, actual %02h", frame_byte_o);
          fail_count++;
        end else begin
          want = pending_bytes.pop_front();
          if (frame_byte_o !== want) begin
            $error("frame_byte: expected %02h, actual %02h", want, frame_byte_o);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        blit_frame(op_i, origin_line_i, origin_column_i, sprite_page_i, sprite_column_i,
                   pixel_byte_i, read_page_i, read_column_i, has_byte, rd_byte);
        if (has_byte) pending_bytes.push_back(typed_valid ? typed_byte : rd_byte);
      end
    end
    if ((start && !busy) || strobe_o) begin
      stall_cycles = 0;
    end else if (++stall_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic issue(input blit_req_t r);
    start           <= 1'b1;
    op_i            <= r.op;
    origin_line_i   <= r.origin_line;
    origin_column_i <= r.origin_column;
    sprite_page_i   <= r.sprite_page;
    sprite_column_i <= r.sprite_column;
    pixel_byte_i    <= r.pixel_byte;
    read_page_i     <= r.read_page;
    read_column_i   <= r.read_column;
    typed_valid     <= r.typed;
    typed_byte      <= r.typed_byte;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drain_reads();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_bytes.size() != 0);
  endtask

  initial begin
    int        idle_pct [4] = '{0, 82, 17, 0};
    int        sent;
    int        kind;
    int        ln;
    int        pg;
    int        cl;
    blit_req_t r;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) issue(directed_rows[i]);
    drain_reads();

    foreach (idle_pct[p]) begin
      sent = 0;
      while (sent < PHASE_REQUESTS) begin
        r.op            = 2'($urandom);
        r.origin_line   = 8'($urandom);
        r.origin_column = 8'($urandom);
        r.sprite_page   = 3'($urandom);
        r.sprite_column = 7'($urandom);
        r.pixel_byte    = 8'($urandom);
        r.read_page     = 3'($urandom);
        r.read_column   = 7'($urandom);
        r.typed         = 1'b0;
        r.typed_byte    = '0;
        kind = int'($urandom_range(99));
        if (kind < 50) begin
          r.op = pfsb_pkg::OP_DRAW;
          // mostly sprites that land on screen
          if ($urandom_range(4) != 0) begin
            r.origin_line   = 8'($urandom_range(79) - 16);
            r.origin_column = 8'($urandom_range(119) - 8);
            r.sprite_page   = 3'($urandom_range(2));
            r.sprite_column = 7'($urandom_range(15));
          end
          ln = $signed(r.origin_line);
          cl = $signed(r.origin_column);
          cl = cl + int'(r.sprite_column);
          pg = (ln >>> 3) + int'(r.sprite_page);
          if (pg >= 0 && pg < PAGE_COUNT && cl >= 0 && cl < COLUMN_COUNT) begin
            last_page = pg;
            last_col = cl;
          end
        end else begin
          r.op = (kind < 75) ? pfsb_pkg::OP_READ :
                 (kind < 95) ? pfsb_pkg::OP_READ_CLEAR : OP_UNUSED;
          if ($urandom_range(1) == 0) begin
            r.read_page   = 3'(last_page);
            r.read_column = 7'(last_col);
          end
        end
        issue(r);
        if (r.op != OP_UNUSED) sent++;
        while ($urandom_range(99) < idle_pct[p]) begin
          start <= 1'b0;
          @(posedge clk_i);
        end
      end
      drain_reads();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/pfsb_pkg.sv
hdl/pfsb_place.sv
hdl/page_frame_sprite_blitter_unit.sv
tb/sv/tb_page_frame_sprite_blitter_unit.sv
